@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked property, checked on every edge including reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and character codes for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam logic [7:0] CH_EOF       = 8'h04;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_KILL      = 8'h15;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // Shared counter unit operation
   typedef enum logic [0:0] {
      OP_INC = 1'b0,
      OP_DEC = 1'b1
   } step_op_type;

endpackage

@@ src/cle_channels.sv @@
// ----------------------------------------------------------------------------
// cle channels
// Valid/ready channel interfaces for input bytes, results and the CSR.
// ----------------------------------------------------------------------------
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       out_eof;

   modport source (output valid, output out_byte, output out_last, output out_eof,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input out_eof,
                   output ready);
endinterface

interface cle_csr_if;
   logic valid;
   logic ready;
   logic raw_mode;

   modport source (output valid, output raw_mode, input ready);
   modport sink   (input valid, input raw_mode, output ready);
endinterface

@@ src/cle_line_ram.sv @@
// ----------------------------------------------------------------------------
// cle_line_ram
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cle_line_ram #(
   parameter int Depth  = 64,
   parameter int AddrW  = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [7:0]       rd_data_ff
);

   logic [7:0] store_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

@@ src/cle_step_unit.sv @@
// ----------------------------------------------------------------------------
// cle_step_unit
// Shared increment/decrement unit with an equality compare on the result.
// ----------------------------------------------------------------------------
module cle_step_unit
   import cle_pkg::*;
#(
   parameter int CntW = 7
) (
   input  step_op_type      op,
   input  logic [CntW-1:0]  operand,
   input  logic [CntW-1:0]  limit,
   output logic [CntW-1:0]  result,
   output logic             hit
);

   always_comb begin
      case (op)
         OP_INC:  result = operand + CntW'(1);
         OP_DEC:  result = operand - CntW'(1);
         default: result = operand;
      endcase
   end

   assign hit = (result == limit);

endmodule

@@ src/cooked_line_editor.sv @@
// ----------------------------------------------------------------------------
// cooked_line_editor
// Console input line discipline: raw pass-through or edited line bursts.
// ----------------------------------------------------------------------------
// Each input transaction is taken in IDLE and decoded in the next cycle.
// In raw mode the byte goes out as a single result marked last. In cooked
// mode backspace, kill and ordinary bytes update the line store; newline,
// end-of-file or a full store (LINE_LEN bytes) start a burst. The burst
// reads the store through its registered read port, one byte per READ/EMIT
// pair, and EMIT holds while the result slot is full. End-of-file on an
// empty line gives one result with out_eof set. The single
// increment/decrement unit serves both the fill count and the burst
// pointer. A CSR write (only while idle) sets raw_mode and drops any
// partial line. No clearing pass after reset: the store is read only below
// the fill count, which holds written entries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cooked_line_editor
   import cle_pkg::*;
#(
   parameter int LINE_LEN = 64
) (
   input  logic         clock,
   input  logic         reset,
   cle_req_if.sink      req_chan,
   cle_rsp_if.source    rsp_chan,
   cle_csr_if.sink      csr_chan
);

   localparam int CntW = $clog2(LINE_LEN + 1);   // holds 0..LINE_LEN
   localparam int IdxW = $clog2(LINE_LEN);       // store address

   // Control state
   state_type       state_ff, state_in;
   logic            raw_ff, raw_in;
   logic [CntW-1:0] fill_ff, fill_in;             // line length during a burst
   logic [CntW-1:0] ptr_ff, ptr_in;               // burst read pointer
   logic [7:0]      ch_ff, ch_in;                 // byte under decode

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_eof_ff, rsp_eof_in;

   // Shared unit
   step_op_type     unit_op;
   logic [CntW-1:0] unit_a, unit_lim, unit_res;
   logic            unit_hit;

   // Line store
   logic            wr_en;
   logic [7:0]      rd_data;

   logic            slot_free, req_fire, csr_fire, load_rsp;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   // The result slot can take a new transaction this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Burst walks the pointer against the line length; otherwise the unit
   // steps the fill count and checks it against a full store.
   always_comb begin
      if (state_ff == ST_EMIT) begin
         unit_a   = ptr_ff;
         unit_lim = fill_ff;
         unit_op  = OP_INC;
      end else begin
         unit_a   = fill_ff;
         unit_lim = CntW'(LINE_LEN);
         unit_op  = (ch_ff == CH_BACKSPACE) ? OP_DEC : OP_INC;
      end
   end

   cle_step_unit #(.CntW(CntW)) u_step (
      .op      (unit_op),
      .operand (unit_a),
      .limit   (unit_lim),
      .result  (unit_res),
      .hit     (unit_hit)
   );

   cle_line_ram #(.Depth(LINE_LEN), .AddrW(IdxW)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (fill_ff[IdxW-1:0]),
      .wr_data    (ch_ff),
      .rd_addr    (ptr_ff[IdxW-1:0]),
      .rd_data_ff (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      raw_in      = raw_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      ch_in       = ch_ff;
      wr_en       = 1'b0;
      load_rsp    = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_eof_in  = rsp_eof_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               raw_in  = csr_chan.raw_mode;
               fill_in = '0;
            end
            if (req_fire) begin
               ch_in    = req_chan.in_byte;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            if (raw_ff) begin
               if (slot_free) begin
                  load_rsp    = 1'b1;
                  rsp_byte_in = ch_ff;
                  rsp_last_in = 1'b1;
                  rsp_eof_in  = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else begin
               case (ch_ff)
                  CH_BACKSPACE: begin
                     if (fill_ff != '0) begin
                        fill_in = unit_res;
                     end
                     state_in = ST_IDLE;
                  end
                  CH_KILL: begin
                     fill_in  = '0;
                     state_in = ST_IDLE;
                  end
                  CH_EOF: begin
                     if (fill_ff == '0) begin
                        // empty line: lone end-of-file result
                        if (slot_free) begin
                           load_rsp    = 1'b1;
                           rsp_byte_in = '0;
                           rsp_last_in = 1'b1;
                           rsp_eof_in  = 1'b1;
                           state_in    = ST_IDLE;
                        end
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     wr_en   = 1'b1;
                     fill_in = unit_res;
                     if ((ch_ff == CH_NEWLINE) || unit_hit) begin
                        ptr_in   = '0;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               endcase
            end
         end

         ST_READ: begin
            // read data for ptr_ff lands in the RAM output register
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (slot_free) begin
               load_rsp    = 1'b1;
               rsp_byte_in = rd_data;
               rsp_last_in = unit_hit;
               rsp_eof_in  = 1'b0;
               if (unit_hit) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = unit_res;
                  state_in = ST_READ;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_ff       <= 1'b0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_ff       <= raw_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff  <= rsp_eof_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;
   assign rsp_chan.out_eof  = rsp_eof_ff;

   // A line never rests in the store at full length
   `ASSERT_PROP(a_fill_below_len, clock, reset, (state_ff == ST_IDLE) |-> (fill_ff < CntW'(LINE_LEN)), "fill count reached line length while idle")
   // Burst pointer stays inside the line being drained
   `ASSERT_PROP(a_ptr_in_line, clock, reset, (state_ff == ST_EMIT) |-> (ptr_ff < fill_ff), "burst pointer past line length")
   // End-of-file result is always a complete run by itself
   `ASSERT_PROP(a_eof_is_last, clock, reset, (rsp_valid_ff && rsp_eof_ff) |-> (rsp_last_ff && (rsp_byte_ff == 8'h00)), "eof result not marked last or byte nonzero")
   // A non-final burst byte is followed by another read of the store
   `ASSERT_PROP(a_burst_continues, clock, reset, ((state_ff == ST_EMIT) && slot_free && !unit_hit) |=> (state_ff == ST_READ), "burst stopped before last byte")

endmodule

@@ verif/cooked_line_editor_tb.sv @@
// ----------------------------------------------------------------------------
// cooked_line_editor_tb
// Self-checking bench for the console line editor. Drives console bytes in
// cooked and raw mode under random source and sink idling, predicts each
// emitted byte with a shadow line store, and compares results field by field.
// ----------------------------------------------------------------------------
module cooked_line_editor_tb;
   import cle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CAP    = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 40;   // mismatch lines printed before going quiet

   // one expected result transaction
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       eof;
   } console_out_type;

   logic clock = 1'b0;
   logic reset;

   cle_req_if req_if ();
   cle_rsp_if rsp_if ();
   cle_csr_if csr_if ();

   cooked_line_editor #(.LINE_LEN(LINE_CAP)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the line discipline: mode, line store, fill count
   // ---------------------------------------------------------------------
   logic            mode_raw;
   logic [7:0]      line_shadow [LINE_CAP];
   logic [6:0]      held_count;

   logic [7:0]      typed_keys [$];     // bytes waiting to be driven
   console_out_type line_out_due [$];   // results still owed by the block

   int unsigned     keys_queued, keys_taken;
   int unsigned     results_seen, eof_lines, full_lines, raw_passes, mode_writes;
   int unsigned     errors, cycle_count;
   int unsigned     send_idle_pct, recv_idle_pct;
   console_out_type head_due;

   task automatic log_mismatch(input string what);
      if (errors < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // Emit the held line as a burst; empty line means end-of-file marker.
   function automatic void flush_line(input int unsigned len);
      console_out_type r;
      if (len == 0) begin
         r = '{data: 8'h00, last: 1'b1, eof: 1'b1};
         line_out_due.push_back(r);
         eof_lines++;
         return;
      end
      for (int unsigned i = 0; i < len; i++) begin
         r.data = line_shadow[i[5:0]];
         r.last = (i + 1 == len);
         r.eof  = 1'b0;
         line_out_due.push_back(r);
      end
   endfunction

   // Apply one accepted byte to the shadow and queue what it produces.
   function automatic void edit_line(input logic [7:0] ch);
      console_out_type r;
      int unsigned     len;
      if (mode_raw) begin
         r = '{data: ch, last: 1'b1, eof: 1'b0};
         line_out_due.push_back(r);
         raw_passes++;
         return;
      end
      if (ch == CH_BACKSPACE) begin
         if (held_count != '0)
            held_count--;
      end else if (ch == CH_KILL) begin
         held_count = '0;
      end else if (ch == CH_EOF) begin
         len = 32'(held_count);
         held_count = '0;
         flush_line(len);
      end else begin
         line_shadow[held_count[5:0]] = ch;
         held_count++;
         if (ch == CH_NEWLINE || held_count >= 7'(LINE_CAP)) begin
            if (ch != CH_NEWLINE)
               full_lines++;
            len = 32'(held_count);
            held_count = '0;
            flush_line(len);
         end
      end
   endfunction

   function automatic void type_key(input logic [7:0] b);
      typed_keys.push_back(b);
      keys_queued++;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued bytes, predicts on each accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.in_byte <= 8'h00;
      end else begin
         if (req_if.valid && req_if.ready) begin
            edit_line(req_if.in_byte);
            keys_taken++;
         end
         // load the next byte only when the slot is free or just drained
         if (!req_if.valid || req_if.ready) begin
            if (typed_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.in_byte <= typed_keys.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, in-order compare against the due queue
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (line_out_due.size() == 0) begin
               log_mismatch($sformatf("unexpected result byte=%02h last=%b eof=%b",
                                      rsp_if.out_byte, rsp_if.out_last, rsp_if.out_eof));
            end else begin
               head_due = line_out_due.pop_front();
               if (rsp_if.out_byte !== head_due.data)
                  log_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_if.out_byte, head_due.data));
               if (rsp_if.out_last !== head_due.last)
                  log_mismatch($sformatf("out_last %b, want %b (byte %02h)",
                                         rsp_if.out_last, head_due.last, head_due.data));
               if (rsp_if.out_eof !== head_due.eof)
                  log_mismatch($sformatf("out_eof %b, want %b (byte %02h)",
                                         rsp_if.out_eof, head_due.eof, head_due.data));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run exceeded %0d cycles, %0d results still due",
                  CYCLE_LIMIT, line_out_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Wait for every byte to be taken and every result returned, then let the
   // clock run on: a byte that ends no line is still being decoded.
   task automatic wait_drained();
      while (keys_taken != keys_queued || line_out_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // CSR write, only ever issued from an idle block. Drops the partial line.
   task automatic set_raw_mode(input logic mode);
      @(posedge clock);
      csr_if.valid    <= 1'b1;
      csr_if.raw_mode <= mode;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      mode_raw   = mode;
      held_count = '0;
      mode_writes++;
   endtask

   // Ordinary character: anything but the four control codes.
   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == CH_BACKSPACE || b == CH_KILL || b == CH_NEWLINE || b == CH_EOF);
      return b;
   endfunction

   // Mostly well-formed lines with random content and some edits; a few long
   // ones to fill the store; a sprinkle of fully random bytes as noise.
   task automatic plan_cooked(input int unsigned n);
      int unsigned made, len, pick;
      logic [7:0]  b;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 8)
            len = $urandom_range(66, 62);
         else
            len = $urandom_range(12, 0);
         for (int unsigned k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
               b = CH_BACKSPACE;
            else if (pick < 8)
               b = CH_KILL;
            else if (pick < 12)
               b = 8'($urandom);
            else
               b = plain_char();
            type_key(b);
         end
         made += len;
         pick = $urandom_range(99);
         if (pick < 55) begin
            type_key(CH_NEWLINE);
            made++;
         end else if (pick < 85) begin
            type_key(CH_EOF);
            made++;
         end
      end
   endtask

   task automatic plan_raw(input int unsigned n);
      logic [7:0] b;
      for (int unsigned k = 0; k < n; k++) begin
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
               0:       b = CH_BACKSPACE;
               1:       b = CH_KILL;
               2:       b = CH_NEWLINE;
               default: b = CH_EOF;
            endcase
         end else begin
            b = 8'($urandom);
         end
         type_key(b);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.in_byte  = 8'h00;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.raw_mode = 1'b0;
      mode_raw        = 1'b0;
      held_count      = '0;
      send_idle_pct   = 31;
      recv_idle_pct   = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, cooked mode out of reset
      type_key(CH_EOF);                       // end-of-file on an empty line
      type_key(CH_BACKSPACE);                 // backspace with nothing held
      type_key(8'h41);                        // "AB", rub out B, newline
      type_key(8'h42);
      type_key(CH_BACKSPACE);
      type_key(CH_NEWLINE);
      type_key(8'h78);                        // x, kill, y, end-of-file
      type_key(CH_KILL);
      type_key(8'h79);
      type_key(CH_EOF);
      type_key(8'h00);                        // byte extremes in one line
      type_key(8'hFF);
      type_key(CH_NEWLINE);
      type_key(8'h71);                        // partial line left behind
      type_key(8'h72);
      wait_drained();
      set_raw_mode(1'b0);                     // same mode, still drops "qr"
      type_key(8'h7A);
      type_key(CH_NEWLINE);
      wait_drained();

      // directed, raw mode: control codes pass straight through
      set_raw_mode(1'b1);
      type_key(8'h00);
      type_key(8'hFF);
      type_key(CH_EOF);
      type_key(CH_BACKSPACE);
      type_key(CH_NEWLINE);
      type_key(CH_KILL);
      type_key(8'h55);
      wait_drained();
      set_raw_mode(1'b0);

      // random rounds: receiver-heavy idling, sender-heavy, then none
      for (int round = 0; round < 3; round++) begin
         case (round)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         plan_cooked(90);
         wait_drained();
         set_raw_mode(1'b1);                  // may discard a partial line
         plan_raw(40);
         wait_drained();
         set_raw_mode(1'b0);
      end

      wait_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d input bytes, %0d results, %0d mode writes",
               keys_taken, results_seen, mode_writes);
      $display("  %0d raw pass-throughs, %0d empty end-of-file lines, %0d full-store lines",
               raw_passes, eof_lines, full_lines);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/cle_pkg.sv
src/cle_channels.sv
src/cle_line_ram.sv
src/cle_step_unit.sv
src/cooked_line_editor.sv
verif/cooked_line_editor_tb.sv
